// ----- hdl/bpr_pkg.sv -----
// Shared types and constants for the bitmap pixel to RGBA converter.
// No dependencies; every other file but bpr_ram imports this package.
`timescale 1ns / 1ps

package bpr_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] raw_byte;
    logic       row_last;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       last;
  } out_t;

  // register indexes
  localparam logic [2:0] CFG_PIXEL_BITS    = 3'd0;
  localparam logic [2:0] CFG_ROW_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_MASK_R        = 3'd2;
  localparam logic [2:0] CFG_MASK_G        = 3'd3;
  localparam logic [2:0] CFG_MASK_B        = 3'd4;
  localparam logic [2:0] CFG_MASK_A        = 3'd5;
  localparam logic [2:0] CFG_PALETTE_COUNT = 3'd6;

  // command codes
  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  // pixel formats
  localparam logic [5:0] BPP_1  = 6'd1;
  localparam logic [5:0] BPP_4  = 6'd4;
  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  localparam logic [14:0] MAX_ROW_WIDTH = 15'd16384;

  localparam logic [31:0] DEF_MASK_R = 32'h00ff0000;
  localparam logic [31:0] DEF_MASK_G = 32'h0000ff00;
  localparam logic [31:0] DEF_MASK_B = 32'h000000ff;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

// ----- hdl/bpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bpr_scale.sv -----
// Bitfield channel scaler: mask, shift down, then value*255/(2^k-1), low 8 bits.
// Iterative: one shift, count or quotient bit per cycle. Uses bpr_pkg.
`timescale 1ns / 1ps

module bpr_scale
  import bpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] word,
  input  logic [31:0] mask,
  input  logic        is_alpha,
  output logic        done,
  output logic [7:0]  result
);

  localparam logic [1:0] SC_IDLE  = 2'd0;
  localparam logic [1:0] SC_SHIFT = 2'd1;
  localparam logic [1:0] SC_COUNT = 2'd2;
  localparam logic [1:0] SC_DIV   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] m_r, m_nxt;
  logic [31:0] w_r, w_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [39:0] n_r, n_nxt;
  logic [32:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  result_r, result_nxt;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem_r, n_r[39]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    w_nxt      = w_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          if (mask == 32'd0) begin
            result_nxt = is_alpha ? ALPHA_OPAQUE : 8'd0;
            done_nxt   = 1'b1;
          end else begin
            m_nxt     = mask;
            w_nxt     = word & mask;
            state_nxt = SC_SHIFT;
          end
        end
      end
      SC_SHIFT: begin
        // drop trailing zeros of the mask
        if (m_r[0]) begin
          k_nxt     = 6'd0;
          state_nxt = SC_COUNT;
        end else begin
          m_nxt = m_r >> 1;
          w_nxt = w_r >> 1;
        end
      end
      SC_COUNT: begin
        // count the run of ones at the bottom
        if (m_r[0]) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + 6'd1;
        end else begin
          n_nxt     = {w_r, 8'd0} - {8'd0, w_r};
          den_nxt   = (33'd1 << k_r) - 33'd1;
          rem_nxt   = 33'd0;
          q_nxt     = 8'd0;
          cnt_nxt   = 6'd0;
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        rem_nxt = ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
        q_nxt   = {q_r[6:0], ge};
        n_nxt   = n_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd39) begin
          result_nxt = q_nxt;
          done_nxt   = 1'b1;
          state_nxt  = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    m_r      <= m_nxt;
    w_r      <= w_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// ----- hdl/bitmap_pixel_to_rgba.sv -----
// Top level of the bitmap pixel to RGBA converter: sequencer, palette RAM,
// byte assembly and bitfield scaler. Uses bpr_pkg, bpr_ram and bpr_scale.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_data  (in_t)
//   out_    | output    | out_valid / out_ready | out_data (out_t)
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// Steps: a palette write or a byte that only gathers is done in its accept
// cycle. Each palette pixel then passes a RAM read state and an output load
// state. A 24-bit or default 32-bit pixel passes the emit state only.
// A bitfield pixel runs the shared scaler four times; per channel the scaler
// shifts out the trailing zeros of its mask, counts its ones and runs 40
// quotient steps, with handoff states between channels.
// Reset is synchronous; the palette RAM holds garbage until written.
// A stalled output holds the sequencer on its next pixel; in_ready stays low
// until the last pixel of the request sits in the output register.
`timescale 1ns / 1ps

module bitmap_pixel_to_rgba
  import bpr_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PAL_RD   = 3'd1;
  localparam logic [2:0] ST_PAL_WAIT = 3'd2;
  localparam logic [2:0] ST_EMIT     = 3'd3;
  localparam logic [2:0] ST_BF_START = 3'd4;
  localparam logic [2:0] ST_BF_WAIT  = 3'd5;

  // configuration
  logic [5:0]  pixel_bits_r;
  logic [14:0] row_width_r;
  logic [31:0] mask_r_r, mask_g_r, mask_b_r, mask_a_r;
  logic [8:0]  palette_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bits_r    <= BPP_24;
      row_width_r     <= 15'd1;
      mask_r_r        <= DEF_MASK_R;
      mask_g_r        <= DEF_MASK_G;
      mask_b_r        <= DEF_MASK_B;
      mask_a_r        <= 32'd0;
      palette_count_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_BITS:    pixel_bits_r    <= cfg_wdata[5:0];
        CFG_ROW_WIDTH:     row_width_r     <= cfg_wdata[14:0];
        CFG_MASK_R:        mask_r_r        <= cfg_wdata;
        CFG_MASK_G:        mask_g_r        <= cfg_wdata;
        CFG_MASK_B:        mask_b_r        <= cfg_wdata;
        CFG_MASK_A:        mask_a_r        <= cfg_wdata;
        CFG_PALETTE_COUNT: palette_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]  state_r, state_nxt;
  logic [14:0] pd_r, pd_nxt;          // pixels done in this row
  logic [23:0] asm_r, asm_nxt;        // gathered low bytes
  logic [1:0]  gath_r, gath_nxt;
  logic [7:0]  pb_r, pb_nxt;          // palette byte, next index at the top
  logic [3:0]  left_r, left_nxt;      // palette pixels left in this byte
  logic        row_last_r, row_last_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [7:0]  red_r, red_nxt, green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt, alpha_r, alpha_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic [14:0] width;
  logic        more;
  logic        slot_free;
  logic        accept;
  logic        pal_mode, multi_mode;
  logic [2:0]  need;
  logic [31:0] c_word;
  logic        complete;
  logic        def_masks;
  logic [7:0]  pal_idx;
  logic        idx_bad;
  logic        ram_we, ram_re;
  logic [23:0] ram_q;
  logic        pd_hits;
  logic        pal_last;
  logic        sc_start, sc_done;
  logic [31:0] sc_mask;
  logic [7:0]  sc_result;

  // row width clamp; the register cannot exceed 15 bits
  assign width     = (row_width_r > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width_r;
  assign more      = pd_r < width;
  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);

  assign pal_mode   = (pixel_bits_r == BPP_1) || (pixel_bits_r == BPP_4) ||
                      (pixel_bits_r == BPP_8);
  assign multi_mode = (pixel_bits_r == BPP_16) || (pixel_bits_r == BPP_24) ||
                      (pixel_bits_r == BPP_32);
  assign def_masks  = (mask_r_r == DEF_MASK_R) && (mask_g_r == DEF_MASK_G) &&
                      (mask_b_r == DEF_MASK_B);

  always_comb begin
    case (pixel_bits_r)
      BPP_16: need = 3'd2;
      BPP_24: need = 3'd3;
      default: need = 3'd4;
    endcase
  end

  // new byte on top of the gathered low bytes
  always_comb begin
    case (pixel_bits_r)
      BPP_16: c_word = {16'd0, in_data.raw_byte, asm_r[7:0]};
      BPP_24: c_word = {8'd0, in_data.raw_byte, asm_r[15:0]};
      default: c_word = {in_data.raw_byte, asm_r};
    endcase
  end

  assign complete = ({1'b0, gath_r} + 3'd1) >= need;

  always_comb begin
    case (pixel_bits_r)
      BPP_1: pal_idx = {7'd0, pb_r[7]};
      BPP_4: pal_idx = {4'd0, pb_r[7:4]};
      default: pal_idx = pb_r;
    endcase
  end

  assign idx_bad = ({1'b0, pal_idx} >= palette_count_r) ||
                   ({1'b0, pal_idx} >= 9'(PALETTE_DEPTH));

  assign ram_we = accept && (in_data.cmd == CMD_PALETTE) &&
                  ({1'b0, in_data.pal_index} < 9'(PALETTE_DEPTH));
  assign ram_re = (state_r == ST_PAL_RD);

  bpr_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_data.pal_index[AW-1:0]),
    .wdata({in_data.pal_red, in_data.pal_green, in_data.pal_blue}),
    .re   (ram_re),
    .raddr(idx_bad ? AW'(0) : pal_idx[AW-1:0]),
    .rdata(ram_q)
  );

  always_comb begin
    case (ch_r)
      2'd0: sc_mask = mask_r_r;
      2'd1: sc_mask = mask_g_r;
      2'd2: sc_mask = mask_b_r;
      default: sc_mask = mask_a_r;
    endcase
  end

  assign sc_start = (state_r == ST_BF_START);

  bpr_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sc_start),
    .word    (word_r),
    .mask    (sc_mask),
    .is_alpha(ch_r == 2'd3),
    .done    (sc_done),
    .result  (sc_result)
  );

  assign pd_hits  = (pd_r + 15'd1) == width;
  assign pal_last = (left_r == 4'd1) || ((pd_r + 15'd1) >= width);

  always_comb begin
    state_nxt     = state_r;
    pd_nxt        = pd_r;
    asm_nxt       = asm_r;
    gath_nxt      = gath_r;
    pb_nxt        = pb_r;
    left_nxt      = left_r;
    row_last_nxt  = row_last_r;
    word_nxt      = word_r;
    ch_nxt        = ch_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    alpha_nxt     = alpha_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.cmd == CMD_PIXEL)) begin
          row_last_nxt = in_data.row_last;
          if (pal_mode) begin
            asm_nxt  = 24'd0;
            gath_nxt = 2'd0;
            if (more) begin
              pb_nxt = in_data.raw_byte;
              case (pixel_bits_r)
                BPP_1: left_nxt = 4'd8;
                BPP_4: left_nxt = 4'd2;
                default: left_nxt = 4'd1;
              endcase
              state_nxt = ST_PAL_RD;
            end else if (in_data.row_last) begin
              pd_nxt = 15'd0;
            end
          end else if (multi_mode && more) begin
            if (complete) begin
              asm_nxt  = 24'd0;
              gath_nxt = 2'd0;
              if (pixel_bits_r == BPP_24) begin
                red_nxt   = c_word[23:16];
                green_nxt = c_word[15:8];
                blue_nxt  = c_word[7:0];
                alpha_nxt = ALPHA_OPAQUE;
                state_nxt = ST_EMIT;
              end else if ((pixel_bits_r == BPP_32) && def_masks) begin
                red_nxt   = c_word[23:16];
                green_nxt = c_word[15:8];
                blue_nxt  = c_word[7:0];
                alpha_nxt = (mask_a_r != 32'd0) ? c_word[31:24] : ALPHA_OPAQUE;
                state_nxt = ST_EMIT;
              end else begin
                word_nxt  = c_word;
                ch_nxt    = 2'd0;
                state_nxt = ST_BF_START;
              end
            end else begin
              asm_nxt  = asm_r | 24'({16'd0, in_data.raw_byte} << {gath_r, 3'd0});
              gath_nxt = gath_r + 2'd1;
              if (in_data.row_last) begin
                pd_nxt   = 15'd0;
                asm_nxt  = 24'd0;
                gath_nxt = 2'd0;
              end
            end
          end else if (in_data.row_last) begin
            // no pixel from this byte: just close the row
            pd_nxt   = 15'd0;
            asm_nxt  = 24'd0;
            gath_nxt = 2'd0;
          end
        end
      end
      ST_PAL_RD: begin
        state_nxt = ST_PAL_WAIT;
      end
      ST_PAL_WAIT: begin
        // hold the RAM data until the output register frees up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{red: ram_q[23:16], green: ram_q[15:8], blue: ram_q[7:0],
                            alpha: ALPHA_OPAQUE, row_end: pd_hits, last: pal_last};
          pd_nxt   = pd_r + 15'd1;
          left_nxt = left_r - 4'd1;
          case (pixel_bits_r)
            BPP_1: pb_nxt = pb_r << 1;
            BPP_4: pb_nxt = pb_r << 4;
            default: pb_nxt = pb_r;
          endcase
          if (pal_last) begin
            if (row_last_r) begin
              pd_nxt = 15'd0;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PAL_RD;
          end
        end
      end
      ST_BF_START: begin
        state_nxt = ST_BF_WAIT;
      end
      ST_BF_WAIT: begin
        if (sc_done) begin
          case (ch_r)
            2'd0: red_nxt = sc_result;
            2'd1: green_nxt = sc_result;
            2'd2: blue_nxt = sc_result;
            default: alpha_nxt = sc_result;
          endcase
          if (ch_r == 2'd3) begin
            state_nxt = ST_EMIT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = ST_BF_START;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{red: red_r, green: green_r, blue: blue_r,
                            alpha: alpha_r, row_end: pd_hits, last: 1'b1};
          pd_nxt = pd_r + 15'd1;
          if (row_last_r) begin
            pd_nxt   = 15'd0;
            asm_nxt  = 24'd0;
            gath_nxt = 2'd0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pd_r        <= 15'd0;
      asm_r       <= 24'd0;
      gath_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pd_r        <= pd_nxt;
      asm_r       <= asm_nxt;
      gath_r      <= gath_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pb_r       <= pb_nxt;
    left_r     <= left_nxt;
    row_last_r <= row_last_nxt;
    word_r     <= word_nxt;
    ch_r       <= ch_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    alpha_r    <= alpha_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/bpr_chk.sv -----
// Port-level checker for bitmap_pixel_to_rgba, bound to the top level.
// Uses bpr_pkg.
`timescale 1ns / 1ps

module bpr_chk
  import bpr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // drop nothing out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // the pixel that closes a row also closes its request
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.last)
    else $error("row end without last");

  // palette writes produce no result
  a_pal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == CMD_PALETTE) && !out_valid |=> !out_valid)
    else $error("result after palette write");

endmodule

bind bitmap_pixel_to_rgba bpr_chk u_bpr_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
